[rtl/core/sorted_merge_with_sum_combine_assert.svh]
// Assertion macros shared by the merge block's RTL files.
// Expects signals named clock and reset in the including module.
`ifndef SORTED_MERGE_WITH_SUM_COMBINE_ASSERT_SVH
`define SORTED_MERGE_WITH_SUM_COMBINE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define SMC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define SMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/smc_pkg.sv]
// Shared types, codes and constants of the two-way sorted merge block.
// No dependencies; used by every module of the block.
package smc_pkg;

   localparam int KEY_BYTES     = 16;
   localparam int COUNT_BITS    = 32;
   localparam int KEY_HALF_BITS = 64;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [KEY_HALF_BITS-1:0] KEY_HIGH_MASK =
      (KEY_BYTES >= 8) ? {KEY_HALF_BITS{1'b1}} :
      ({KEY_HALF_BITS{1'b1}} << (8 * (8 - KEY_BYTES)));
   localparam logic [KEY_HALF_BITS-1:0] KEY_LOW_MASK =
      (KEY_BYTES <= 8) ? {KEY_HALF_BITS{1'b0}} :
      ({KEY_HALF_BITS{1'b1}} << (8 * (16 - KEY_BYTES)));
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      KIND_FIRST_REC  = 2'd0,
      KIND_SECOND_REC = 2'd1,
      KIND_FIRST_END  = 2'd2,
      KIND_SECOND_END = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_HEAD_FULL = 2'd1,
      STATUS_RUN_ENDED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SIDE_FIRST  = 2'd0,
      SIDE_SECOND = 2'd1,
      SIDE_EITHER = 2'd2,
      SIDE_NONE   = 2'd3
   } side_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [KEY_HALF_BITS-1:0] key_high;
      logic [KEY_HALF_BITS-1:0] key_low;
      logic [COUNT_BITS-1:0]    count_a;
      logic [COUNT_BITS-1:0]    count_b;
   } req_payload_type;

   typedef struct packed {
      logic                     emitted;
      logic [KEY_HALF_BITS-1:0] out_key_high;
      logic [KEY_HALF_BITS-1:0] out_key_low;
      logic [COUNT_BITS-1:0]    out_count_a;
      logic [COUNT_BITS-1:0]    out_count_b;
      logic                     combined;
      logic                     saturated;
      logic [1:0]               next_side;
      logic                     all_done;
      logic [1:0]               status;
   } rsp_payload_type;

   // Classified item as it travels from front to back.
   typedef struct packed {
      logic                     is_end;
      logic                     side;
      logic [KEY_HALF_BITS-1:0] key_high;
      logic [KEY_HALF_BITS-1:0] key_low;
      logic [COUNT_BITS-1:0]    count_a;
      logic [COUNT_BITS-1:0]    count_b;
   } item_type;

   typedef struct packed {
      logic                     valid;
      logic                     ended;
      logic [KEY_HALF_BITS-1:0] key_high;
      logic [KEY_HALF_BITS-1:0] key_low;
      logic [COUNT_BITS-1:0]    count_a;
      logic [COUNT_BITS-1:0]    count_b;
   } head_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_state_type;

endpackage

[rtl/core/smc_front.sv]
// Front part of the merge block: takes request beats, decodes the kind
// and masks the key, then hands items to the queue. Uses smc_pkg.
module smc_front
   import smc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   input  queue_state_type q_state,
   output logic            push,
   output item_type        push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign push      = valid_ff && !q_state.full;
   assign push_item = item_ff;
   assign req_stall = valid_ff && q_state.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in          = item_ff;
      item_in.key_high = req_data.key_high & KEY_HIGH_MASK;
      item_in.key_low  = req_data.key_low & KEY_LOW_MASK;
      item_in.count_a  = req_data.count_a;
      item_in.count_b  = req_data.count_b;
      case (req_data.kind)
         KIND_FIRST_REC: begin
            item_in.is_end = 1'b0;
            item_in.side   = 1'b0;
         end
         KIND_SECOND_REC: begin
            item_in.is_end = 1'b0;
            item_in.side   = 1'b1;
         end
         KIND_FIRST_END: begin
            item_in.is_end = 1'b1;
            item_in.side   = 1'b0;
         end
         KIND_SECOND_END: begin
            item_in.is_end = 1'b1;
            item_in.side   = 1'b1;
         end
         default: begin
            item_in.is_end = 1'b1;
            item_in.side   = 1'b1;
         end
      endcase

      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/core/smc_queue.sv]
// Short item queue between the front and back parts of the merge block.
// Register based, first in first out. Uses smc_pkg.
`include "sorted_merge_with_sum_combine_assert.svh"

module smc_queue
   import smc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  item_type        push_item,
   input  logic            pop,
   output item_type        head_item,
   output queue_state_type q_state
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDE = $clog2(QUEUE_DEPTH + 1);

   item_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDE-1:0] count_ff, count_in;

   assign head_item         = slot_ff[rd_ptr_ff];
   assign q_state.full      = (count_ff == COUNT_WIDE'(QUEUE_DEPTH));
   assign q_state.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SMC_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_WIDE'(QUEUE_DEPTH), "queue overfilled")
   `SMC_ASSERT_SAME(a_no_push_full, push, !q_state.full, "push into full queue")
   `SMC_ASSERT_SAME(a_no_pop_empty, pop, q_state.not_empty, "pop from empty queue")

endmodule

[rtl/core/smc_back.sv]
// Back part of the merge block: holds one head record per run, applies
// each queued item, picks or combines the smaller head and registers the
// result beat. Uses smc_pkg.
`include "sorted_merge_with_sum_combine_assert.svh"

module smc_back
   import smc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  queue_state_type q_state,
   input  item_type        head_item,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   head_type        head0_ff, head0_in;
   head_type        head1_ff, head1_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   assign pop       = q_state.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      head_type               me;
      head_type               oth;
      head_type               held;
      head_type               n0;
      head_type               n1;
      logic                   draining;
      logic                   emit_held;
      logic                   key_lt;
      logic                   key_eq;
      logic [COUNT_BITS:0]    sum_a;
      logic [COUNT_BITS:0]    sum_b;
      logic                   feed0;
      logic                   feed1;
      status_type             st;

      me        = head_item.side ? head1_ff : head0_ff;
      oth       = head_item.side ? head0_ff : head1_ff;
      held      = me;
      draining  = me.valid && oth.ended && !oth.valid;
      emit_held = 1'b0;
      st        = STATUS_OK;

      if (me.ended) begin
         st = STATUS_RUN_ENDED;
      end else if (head_item.is_end) begin
         me.ended = 1'b1;
      end else if (me.valid && !draining) begin
         st = STATUS_HEAD_FULL;
      end else begin
         // draining head leaves as the new record takes its place
         emit_held   = me.valid;
         me.valid    = 1'b1;
         me.key_high = head_item.key_high;
         me.key_low  = head_item.key_low;
         me.count_a  = head_item.count_a;
         me.count_b  = head_item.count_b;
      end

      n0 = head_item.side ? oth : me;
      n1 = head_item.side ? me : oth;

      key_lt = {n0.key_high, n0.key_low} < {n1.key_high, n1.key_low};
      key_eq = {n0.key_high, n0.key_low} == {n1.key_high, n1.key_low};
      sum_a  = {1'b0, n0.count_a} + {1'b0, n1.count_a};
      sum_b  = {1'b0, n0.count_b} + {1'b0, n1.count_b};

      rsp_in = '0;
      if (emit_held) begin
         rsp_in.emitted      = 1'b1;
         rsp_in.out_key_high = held.key_high;
         rsp_in.out_key_low  = held.key_low;
         rsp_in.out_count_a  = held.count_a;
         rsp_in.out_count_b  = held.count_b;
      end else if (n0.valid && n1.valid) begin
         rsp_in.emitted = 1'b1;
         if (key_eq) begin
            rsp_in.out_key_high = n0.key_high;
            rsp_in.out_key_low  = n0.key_low;
            rsp_in.out_count_a  = sum_a[COUNT_BITS] ? COUNT_MAX : sum_a[COUNT_BITS-1:0];
            rsp_in.out_count_b  = sum_b[COUNT_BITS] ? COUNT_MAX : sum_b[COUNT_BITS-1:0];
            rsp_in.combined     = 1'b1;
            rsp_in.saturated    = sum_a[COUNT_BITS] || sum_b[COUNT_BITS];
            n0.valid            = 1'b0;
            n1.valid            = 1'b0;
         end else if (key_lt) begin
            rsp_in.out_key_high = n0.key_high;
            rsp_in.out_key_low  = n0.key_low;
            rsp_in.out_count_a  = n0.count_a;
            rsp_in.out_count_b  = n0.count_b;
            n0.valid            = 1'b0;
         end else begin
            rsp_in.out_key_high = n1.key_high;
            rsp_in.out_key_low  = n1.key_low;
            rsp_in.out_count_a  = n1.count_a;
            rsp_in.out_count_b  = n1.count_b;
            n1.valid            = 1'b0;
         end
      end else if (n0.valid && n1.ended) begin
         rsp_in.emitted      = 1'b1;
         rsp_in.out_key_high = n0.key_high;
         rsp_in.out_key_low  = n0.key_low;
         rsp_in.out_count_a  = n0.count_a;
         rsp_in.out_count_b  = n0.count_b;
         n0.valid            = 1'b0;
      end else if (n1.valid && n0.ended) begin
         rsp_in.emitted      = 1'b1;
         rsp_in.out_key_high = n1.key_high;
         rsp_in.out_key_low  = n1.key_low;
         rsp_in.out_count_a  = n1.count_a;
         rsp_in.out_count_b  = n1.count_b;
         n1.valid            = 1'b0;
      end

      feed0 = !n0.ended && (!n0.valid || (n1.ended && !n1.valid));
      feed1 = !n1.ended && (!n1.valid || (n0.ended && !n0.valid));
      case ({feed0, feed1})
         2'b11:   rsp_in.next_side = SIDE_EITHER;
         2'b10:   rsp_in.next_side = SIDE_FIRST;
         2'b01:   rsp_in.next_side = SIDE_SECOND;
         default: rsp_in.next_side = SIDE_NONE;
      endcase
      rsp_in.all_done = n0.ended && n1.ended && !n0.valid && !n1.valid;
      rsp_in.status   = st;

      head0_in = n0;
      head1_in = n1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head0_ff.valid <= 1'b0;
         head0_ff.ended <= 1'b0;
         head1_ff.valid <= 1'b0;
         head1_ff.ended <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            head0_ff     <= head0_in;
            head1_ff     <= head1_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   `SMC_ASSERT_SAME(a_sat_needs_comb, rsp_valid_ff && rsp_ff.saturated, rsp_ff.combined, "saturated without combine")
   `SMC_ASSERT_SAME(a_done_no_feed, rsp_valid_ff && rsp_ff.all_done, rsp_ff.next_side == SIDE_NONE, "done but run still fed")
   `SMC_ASSERT_NEXT(a_end0_sticky, head0_ff.ended, head0_ff.ended, "first run end flag dropped")
   `SMC_ASSERT_NEXT(a_end1_sticky, head1_ff.ended, head1_ff.ended, "second run end flag dropped")

endmodule

[rtl/core/sorted_merge_with_sum_combine.sv]
// Two-way sorted merge with key aggregation: merges two ascending runs of
// 16-byte keyed records, adding the saturating count sums of equal keys, and
// returns exactly one result beat per request beat. Sustained rate is one
// beat per clock cycle while the result side does not stall. An accepted
// beat is registered in the front part, written to a queue slot, and then
// registered as the result beat on rsp_. The rate is set by the head
// update in the back part, where the key compare and the sum adds are
// combinational and feed the head write-back. A four-entry queue lets the
// request side keep moving while the result side stalls for a short while.
// Depends on smc_pkg, smc_front, smc_queue and smc_back.
module sorted_merge_with_sum_combine
   import smc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   queue_state_type q_state;
   logic            push;
   item_type        push_item;
   logic            pop;
   item_type        head_item;

   smc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_state   (q_state),
      .push      (push),
      .push_item (push_item)
   );

   smc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_state   (q_state)
   );

   smc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_state   (q_state),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[test/sorted_merge_with_sum_combine_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the two-way sorted merge: a directed table, then a long random merge
// session, each result beat checked against its typed row or a predictor of the two run heads.
// Depends on smc_pkg and the sorted_merge_with_sum_combine RTL.
module sorted_merge_with_sum_combine_tb;
   import smc_pkg::*;

   localparam int RANDOM_ITEMS = 1950;
   localparam int END_FROM     = 1900;
   localparam int QUIET_FROM   = 400;
   localparam int QUIET_TO     = 800;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      req_payload_type beat;
      bit              typed;
      rsp_payload_type want;
   } stim_row_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   head_type        run_heads [2];
   logic [127:0]    run_floor [2];
   rsp_payload_type merge_expected [$];
   stim_row_type    stim_rows [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              stall_left  = 0;
   bit              quiet       = 1'b0;

   sorted_merge_with_sum_combine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic req_payload_type mk_beat(input kind_type kind,
                                               input logic [63:0] kh, input logic [63:0] kl,
                                               input logic [31:0] ca, input logic [31:0] cb);
      req_payload_type b;
      b.kind     = kind;
      b.key_high = kh;
      b.key_low  = kl;
      b.count_a  = ca;
      b.count_b  = cb;
      return b;
   endfunction

   function automatic rsp_payload_type mk_result(input logic emitted,
                                                 input logic [63:0] kh, input logic [63:0] kl,
                                                 input logic [31:0] ca, input logic [31:0] cb,
                                                 input logic combined, input logic saturated,
                                                 input side_type next_side,
                                                 input logic all_done,
                                                 input status_type status);
      rsp_payload_type r;
      r.emitted      = emitted;
      r.out_key_high = kh;
      r.out_key_low  = kl;
      r.out_count_a  = ca;
      r.out_count_b  = cb;
      r.combined     = combined;
      r.saturated    = saturated;
      r.next_side    = next_side;
      r.all_done     = all_done;
      r.status       = status;
      return r;
   endfunction

   function automatic rsp_payload_type head_record(input head_type h);
      rsp_payload_type r;
      r              = '0;
      r.emitted      = 1'b1;
      r.out_key_high = h.key_high;
      r.out_key_low  = h.key_low;
      r.out_count_a  = h.count_a;
      r.out_count_b  = h.count_b;
      return r;
   endfunction

   function automatic bit can_feed(input int s);
      return !run_heads[s].ended &&
         (!run_heads[s].valid || (run_heads[1-s].ended && !run_heads[1-s].valid));
   endfunction

   // Apply one accepted request beat to the head copies and return the result beat it causes.
   function automatic rsp_payload_type merge_step(input req_payload_type beat);
      rsp_payload_type     res;
      status_type          status;
      int                  me;
      bit                  draining, took, f0, f1;
      logic [COUNT_BITS:0] sum_a, sum_b;
      res      = '0;
      status   = STATUS_OK;
      me       = int'(beat.kind[0]);
      took     = 1'b0;
      draining = run_heads[me].valid && run_heads[1-me].ended && !run_heads[1-me].valid;
      if (run_heads[me].ended) begin
         status = STATUS_RUN_ENDED;
      end else if (beat.kind[1]) begin
         run_heads[me].ended = 1'b1;
      end else if (run_heads[me].valid && !draining) begin
         status = STATUS_HEAD_FULL;
      end else begin
         // a draining run hands out its held record as the new one lands
         if (run_heads[me].valid) begin
            res  = head_record(run_heads[me]);
            took = 1'b1;
         end
         run_heads[me].valid    = 1'b1;
         run_heads[me].key_high = beat.key_high & KEY_HIGH_MASK;
         run_heads[me].key_low  = beat.key_low & KEY_LOW_MASK;
         run_heads[me].count_a  = beat.count_a;
         run_heads[me].count_b  = beat.count_b;
      end
      if (!took) begin
         if (run_heads[0].valid && run_heads[1].valid) begin
            if ({run_heads[0].key_high, run_heads[0].key_low} ==
                {run_heads[1].key_high, run_heads[1].key_low}) begin
               sum_a           = {1'b0, run_heads[0].count_a} + {1'b0, run_heads[1].count_a};
               sum_b           = {1'b0, run_heads[0].count_b} + {1'b0, run_heads[1].count_b};
               res             = head_record(run_heads[0]);
               res.out_count_a = sum_a[COUNT_BITS] ? COUNT_MAX : sum_a[COUNT_BITS-1:0];
               res.out_count_b = sum_b[COUNT_BITS] ? COUNT_MAX : sum_b[COUNT_BITS-1:0];
               res.combined    = 1'b1;
               res.saturated   = sum_a[COUNT_BITS] | sum_b[COUNT_BITS];
               run_heads[0].valid = 1'b0;
               run_heads[1].valid = 1'b0;
            end else if ({run_heads[0].key_high, run_heads[0].key_low} <
                         {run_heads[1].key_high, run_heads[1].key_low}) begin
               res = head_record(run_heads[0]);
               run_heads[0].valid = 1'b0;
            end else begin
               res = head_record(run_heads[1]);
               run_heads[1].valid = 1'b0;
            end
         end else if (run_heads[0].valid && run_heads[1].ended) begin
            res = head_record(run_heads[0]);
            run_heads[0].valid = 1'b0;
         end else if (run_heads[1].valid && run_heads[0].ended) begin
            res = head_record(run_heads[1]);
            run_heads[1].valid = 1'b0;
         end
      end
      f0            = can_feed(0);
      f1            = can_feed(1);
      res.next_side = (f0 && f1) ? SIDE_EITHER : f0 ? SIDE_FIRST : f1 ? SIDE_SECOND : SIDE_NONE;
      res.all_done  = run_heads[0].ended && run_heads[1].ended &&
                      !run_heads[0].valid && !run_heads[1].valid;
      res.status    = status;
      return res;
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(0, 2))
         0: return 32'($urandom_range(0, 255));
         1: return $urandom;
         default: return COUNT_MAX - 32'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly an ascending record for a run that can take one; now and then a record that
   // lands on a full or ended run, and end marks towards the close of the session.
   function automatic req_payload_type next_merge_beat(input int idx);
      req_payload_type beat;
      bit              feed [2];
      int              side;
      logic [128:0]    sum;
      logic [127:0]    key;
      beat.key_high = {$urandom, $urandom};
      beat.key_low  = {$urandom, $urandom};
      beat.count_a  = rand_count();
      beat.count_b  = rand_count();
      feed[0]       = can_feed(0);
      feed[1]       = can_feed(1);
      if (run_heads[0].ended && run_heads[1].ended) begin
         beat.kind = 2'($urandom_range(0, 3));
      end else if (idx >= END_FROM && (idx >= RANDOM_ITEMS || $urandom_range(0, 9) == 0)) begin
         side = $urandom_range(0, 1);
         if (run_heads[side].ended) side = 1 - side;
         beat.kind = side ? KIND_SECOND_END : KIND_FIRST_END;
      end else if (!(feed[0] && feed[1]) && $urandom_range(0, 99) < 8) begin
         beat.kind = feed[0] ? KIND_SECOND_REC : KIND_FIRST_REC;
      end else begin
         side = (feed[0] && feed[1]) ? $urandom_range(0, 1) : int'(feed[1]);
         if (run_heads[1-side].valid && $urandom_range(0, 2) == 0 &&
             {run_heads[1-side].key_high, run_heads[1-side].key_low} >= run_floor[side]) begin
            // match the other head so the two records combine
            key = {run_heads[1-side].key_high, run_heads[1-side].key_low};
         end else begin
            if ($urandom_range(0, 3) == 0)
               sum = {1'b0, run_floor[side]} + 129'($urandom_range(0, 2));
            else
               sum = {1'b0, run_floor[side]} + (129'($urandom) << $urandom_range(0, 88));
            key = sum[128] ? '1 : sum[127:0];
         end
         run_floor[side]                = key;
         beat.kind                      = side ? KIND_SECOND_REC : KIND_FIRST_REC;
         {beat.key_high, beat.key_low}  = key;
      end
      return beat;
   endfunction

   task automatic send_beat(input req_payload_type beat, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predicted = merge_step(beat);
      merge_expected.push_back(typed ? want : predicted);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (merge_expected.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_side
      rsp_payload_type want;
      int              r;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merge_expected.size() == 0) begin
               $error("result beat with no expectation waiting");
               error_count++;
            end else begin
               want = merge_expected.pop_front();
               check_field("emitted", 64'(want.emitted), 64'(rsp_data.emitted));
               check_field("out_key_high", want.out_key_high, rsp_data.out_key_high);
               check_field("out_key_low", want.out_key_low, rsp_data.out_key_low);
               check_field("out_count_a", 64'(want.out_count_a), 64'(rsp_data.out_count_a));
               check_field("out_count_b", 64'(want.out_count_b), 64'(rsp_data.out_count_b));
               check_field("combined", 64'(want.combined), 64'(rsp_data.combined));
               check_field("saturated", 64'(want.saturated), 64'(rsp_data.saturated));
               check_field("next_side", 64'(want.next_side), 64'(rsp_data.next_side));
               check_field("all_done", 64'(want.all_done), 64'(rsp_data.all_done));
               check_field("status", 64'(want.status), 64'(rsp_data.status));
            end
         end
         // mostly single stalls, now and then a longer hold to fill the queue
         r = $urandom_range(0, 999);
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (!quiet && r < 50) begin
            rsp_stall <= 1'b1;
         end else if (!quiet && r < 53) begin
            stall_left <= $urandom_range(4, 15);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int idx;
      run_heads[0] = '0;
      run_heads[1] = '0;
      run_floor[0] = {64'h8000_0000_0000_0000, 64'h0};
      run_floor[1] = {64'h8000_0000_0000_0000, 64'h0};

      // lowest key with full counts, then a record for the full head
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h0, 64'h0, COUNT_MAX, COUNT_MAX), 1'b1,
         mk_result(1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0, SIDE_SECOND, 1'b0, STATUS_OK)});
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h7fff_ffff_ffff_ffff,
         64'h5a5a_5a5a_5a5a_5a5a, 32'h1234_5678, 32'h0), 1'b1,
         mk_result(1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0, SIDE_SECOND, 1'b0,
                   STATUS_HEAD_FULL)});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h0, 64'h0, 32'h1, 32'h1), 1'b1,
         mk_result(1'b1, 64'h0, 64'h0, COUNT_MAX, COUNT_MAX, 1'b1, 1'b1, SIDE_EITHER, 1'b0,
                   STATUS_OK)});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h0, 64'h1, 32'h8000_0000, 32'h0),
         1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h0, 64'h1, 32'h8000_0000,
         32'h7fff_ffff), 1'b0, '0});
      // sums that reach the maximum exactly
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h0, 64'h2, COUNT_MAX, 32'h0), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h0, 64'h2, 32'h0, COUNT_MAX), 1'b0, '0});
      // high half decides before the low half
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h1, 64'h0, 32'h5, 32'h6), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h0, 64'hffff_ffff_ffff_ffff, 32'h7,
         32'h8), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h0100_0000_0000_0000, 64'h0, 32'h9,
         32'ha), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'hffff_ffff_ffff_ffff,
         64'hffff_ffff_ffff_ffff, COUNT_MAX, COUNT_MAX), 1'b1,
         mk_result(1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 1'b0, SIDE_FIRST, 1'b0,
                   STATUS_HEAD_FULL)});
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h7f00_0000_0000_0000,
         64'h5555_5555_5555_5555, 32'hdead_beef, 32'h0), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h7f00_0000_0000_0000,
         64'haaaa_aaaa_aaaa_aaaa, 32'h1, 32'h0), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h7f00_0000_0000_0000,
         64'haaaa_aaaa_aaaa_aaaa, COUNT_MAX, COUNT_MAX), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_SECOND_REC, 64'h7fff_0000_0000_0000, 64'h0, 32'h0,
         32'h0), 1'b0, '0});
      stim_rows.push_back('{mk_beat(KIND_FIRST_REC, 64'h7fff_0000_0000_0000, 64'h0, 32'h0,
         32'h0), 1'b0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
      hold_until_drained();

      for (idx = 0; idx < RANDOM_ITEMS || !(run_heads[0].ended && run_heads[1].ended);
           idx++) begin
         quiet = (idx >= QUIET_FROM && idx < QUIET_TO);
         if (idx == RANDOM_ITEMS / 2) hold_until_drained();
         send_beat(next_merge_beat(idx), 1'b0, '0);
      end
      hold_until_drained();
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sorted_merge_with_sum_combine.f]
+incdir+rtl/core
rtl/core/smc_pkg.sv
rtl/core/smc_front.sv
rtl/core/smc_queue.sv
rtl/core/smc_back.sv
rtl/core/sorted_merge_with_sum_combine.sv
test/sorted_merge_with_sum_combine_tb.sv
